[hdl/assert_macros.svh]
// Assertion macros used by the hash block's top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define CHECK_IMPLY(name, ck, rs, ante, cons, msg) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition implies another in the following cycle.
`define CHECK_NEXT(name, ck, rs, ante, cons, msg) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/dlmsh_pkg.sv]
// Types, constants and the micro-program of the dual-lane multiply-shift hash.
`default_nettype none

package dlmsh_pkg;

  typedef logic [31:0] word_t;

  // Micro-program length and step counter
  localparam int unsigned ProgLen = 33;
  localparam int unsigned StepW   = $clog2(ProgLen);
  typedef logic [StepW-1:0] step_idx_t;
  localparam step_idx_t LastStep = step_idx_t'(ProgLen - 1);

  // Lane A key offsets
  localparam word_t KeyA1Offset = 32'h69FB_0000;
  localparam word_t KeyA2Offset = 32'h13DB_0000;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  typedef enum logic {
    LANE_A,
    LANE_B
  } lane_t;

  // Multiplier left operand source
  typedef enum logic [2:0] {
    ASEL_CONST,
    ASEL_KEY_A1,
    ASEL_KEY_A2,
    ASEL_KEY_B1,
    ASEL_KEY_B2
  } asel_t;

  // How a product is folded into the accumulator
  typedef enum logic [1:0] {
    MODE_LOAD,
    MODE_ADD,
    MODE_SUB,
    MODE_MOV
  } mode_t;

  // Where a finished step result goes
  typedef enum logic [1:0] {
    POST_NONE,
    POST_V,
    POST_T,
    POST_HASH
  } post_t;

  typedef struct packed {
    logic  issue;
    lane_t lane;
    asel_t asel;
    logic  use_hi;
    word_t coef;
    mode_t mode;
    post_t post;
  } op_t;

  // Control from the sequencer to the lane datapath
  typedef struct packed {
    logic start;
    logic clear;
    op_t  op;
  } lane_ctl_t;

  localparam op_t OpIdle = '{
    issue:  1'b0,
    lane:   LANE_A,
    asel:   ASEL_CONST,
    use_hi: 1'b0,
    coef:   32'h0,
    mode:   MODE_LOAD,
    post:   POST_NONE
  };

  function automatic op_t mk_op(lane_t lane, asel_t asel, logic use_hi, word_t coef,
                                mode_t mode, post_t post);
    op_t o;
    o.issue  = 1'b1;
    o.lane   = lane;
    o.asel   = asel;
    o.use_hi = use_hi;
    o.coef   = coef;
    o.mode   = mode;
    o.post   = post;
    return o;
  endfunction

  // Issue schedule: lane A and lane B pairs interleave so that each lane's
  // next product sees its own previous result; gaps are bubbles.
  function automatic op_t prog(step_idx_t idx);
    op_t o;
    o = OpIdle;
    unique case (idx)
      // lane B: x = key1 * (lo + hash)
      6'd0:  o = mk_op(LANE_B, ASEL_KEY_B1, 1'b0, 32'h0, MODE_MOV, POST_V);
      // lane A: p
      6'd1:  o = mk_op(LANE_A, ASEL_KEY_A1, 1'b0, 32'h0, MODE_LOAD, POST_NONE);
      6'd2:  o = mk_op(LANE_A, ASEL_CONST, 1'b1, 32'h10FA_9605, MODE_SUB, POST_V);
      // lane B: a
      6'd3:  o = mk_op(LANE_B, ASEL_CONST, 1'b0, 32'hB111_0000, MODE_LOAD, POST_NONE);
      6'd4:  o = mk_op(LANE_B, ASEL_CONST, 1'b1, 32'h3067_4EEF, MODE_SUB, POST_V);
      // lane A: q
      6'd5:  o = mk_op(LANE_A, ASEL_CONST, 1'b0, 32'h79F8_A395, MODE_LOAD, POST_NONE);
      6'd6:  o = mk_op(LANE_A, ASEL_CONST, 1'b1, 32'h689B_6B9F, MODE_ADD, POST_V);
      // lane B: b
      6'd7:  o = mk_op(LANE_B, ASEL_CONST, 1'b0, 32'h5B9F_0000, MODE_LOAD, POST_NONE);
      6'd8:  o = mk_op(LANE_B, ASEL_CONST, 1'b1, 32'h78F7_A461, MODE_SUB, POST_V);
      // lane A: t, then u = t + hi
      6'd9:  o = mk_op(LANE_A, ASEL_CONST, 1'b0, 32'hEA97_0001, MODE_LOAD, POST_NONE);
      6'd10: o = mk_op(LANE_A, ASEL_CONST, 1'b1, 32'h3C10_1569, MODE_SUB, POST_T);
      // lane B: c (high half term first)
      6'd11: o = mk_op(LANE_B, ASEL_CONST, 1'b1, 32'h12CE_B96D, MODE_LOAD, POST_NONE);
      6'd12: o = mk_op(LANE_B, ASEL_CONST, 1'b0, 32'h4693_0000, MODE_SUB, POST_V);
      // lane A: v
      6'd13: o = mk_op(LANE_A, ASEL_KEY_A2, 1'b0, 32'h0, MODE_LOAD, POST_NONE);
      6'd14: o = mk_op(LANE_A, ASEL_CONST, 1'b1, 32'h3CE8_EC25, MODE_SUB, POST_V);
      // lane B: t, then t + hi
      6'd15: o = mk_op(LANE_B, ASEL_CONST, 1'b0, 32'h1D83_0000, MODE_LOAD, POST_NONE);
      6'd16: o = mk_op(LANE_B, ASEL_CONST, 1'b1, 32'h257E_1D83, MODE_ADD, POST_T);
      // lane A: w
      6'd17: o = mk_op(LANE_A, ASEL_CONST, 1'b0, 32'h59C3_AF2D, MODE_LOAD, POST_NONE);
      6'd18: o = mk_op(LANE_A, ASEL_CONST, 1'b1, 32'h2232_E0F1, MODE_SUB, POST_V);
      // lane B: d = key2 * (t + hi)
      6'd19: o = mk_op(LANE_B, ASEL_KEY_B2, 1'b0, 32'h0, MODE_MOV, POST_V);
      // lane A: new hash
      6'd20: o = mk_op(LANE_A, ASEL_CONST, 1'b0, 32'h1EC9_0001, MODE_LOAD, POST_NONE);
      6'd21: o = mk_op(LANE_A, ASEL_CONST, 1'b1, 32'h35BD_1EC9, MODE_ADD, POST_HASH);
      // lane B: e
      6'd22: o = mk_op(LANE_B, ASEL_CONST, 1'b0, 32'h16F5_0000, MODE_LOAD, POST_NONE);
      6'd23: o = mk_op(LANE_B, ASEL_CONST, 1'b1, 32'h5D8B_E90B, MODE_SUB, POST_V);
      // lane B: f
      6'd25: o = mk_op(LANE_B, ASEL_CONST, 1'b0, 32'h96FF_0000, MODE_LOAD, POST_NONE);
      6'd26: o = mk_op(LANE_B, ASEL_CONST, 1'b1, 32'h2C7C_6901, MODE_SUB, POST_V);
      // lane B: g
      6'd28: o = mk_op(LANE_B, ASEL_CONST, 1'b0, 32'h2B89_0000, MODE_LOAD, POST_NONE);
      6'd29: o = mk_op(LANE_B, ASEL_CONST, 1'b1, 32'h7C93_2B89, MODE_ADD, POST_V);
      // lane B: new hash
      6'd31: o = mk_op(LANE_B, ASEL_CONST, 1'b0, 32'h9F69_0000, MODE_LOAD, POST_NONE);
      6'd32: o = mk_op(LANE_B, ASEL_CONST, 1'b1, 32'h405B_6097, MODE_SUB, POST_HASH);
      default: o = OpIdle;
    endcase
    return o;
  endfunction

endpackage

`default_nettype wire

[hdl/dlmsh_in_if.sv]
// Input channel: one 8-byte chunk with its key words and last mark.
`default_nettype none

interface dlmsh_in_if;
  logic              valid;
  logic              ready;
  dlmsh_pkg::word_t  word_low;
  dlmsh_pkg::word_t  word_high;
  dlmsh_pkg::word_t  key_first;
  dlmsh_pkg::word_t  key_second;
  logic              last_chunk;

  modport source (
    output valid, word_low, word_high, key_first, key_second, last_chunk,
    input  ready
  );

  modport sink (
    input  valid, word_low, word_high, key_first, key_second, last_chunk,
    output ready
  );
endinterface

`default_nettype wire

[hdl/dlmsh_out_if.sv]
// Output channel: the 64-bit digest as two 32-bit words.
`default_nettype none

interface dlmsh_out_if;
  logic              valid;
  logic              ready;
  dlmsh_pkg::word_t  digest_low;
  dlmsh_pkg::word_t  digest_high;

  modport source (
    output valid, digest_low, digest_high,
    input  ready
  );

  modport sink (
    input  valid, digest_low, digest_high,
    output ready
  );
endinterface

`default_nettype wire

[hdl/dlmsh_lanes.sv]
// Lane datapath: shared multiplier, accumulator and the state of both lanes.
`default_nettype none

module dlmsh_lanes (
  input  logic                   clk,
  input  logic                   rst,
  input  dlmsh_pkg::lane_ctl_t   ctl,
  input  dlmsh_pkg::word_t       word_low,
  input  dlmsh_pkg::word_t       word_high,
  input  dlmsh_pkg::word_t       key_first,
  input  dlmsh_pkg::word_t       key_second,
  output dlmsh_pkg::word_t       digest_low,
  output dlmsh_pkg::word_t       digest_high
);

  // Control that travels with a product to the combine cycle
  typedef struct packed {
    logic              valid;
    dlmsh_pkg::lane_t  lane;
    dlmsh_pkg::mode_t  mode;
    dlmsh_pkg::post_t  post;
  } pend_t;

  dlmsh_pkg::word_t v_a, v_b;
  dlmsh_pkg::word_t t_a, t_b;
  dlmsh_pkg::word_t a_hash, a_cache, b_hash, b_cache;
  dlmsh_pkg::word_t hi_q, k1_q, k2_q;
  dlmsh_pkg::word_t acc, prod;
  pend_t            pend;

  dlmsh_pkg::word_t key_a1, key_a2, key_b1, key_b2;
  dlmsh_pkg::word_t v_sel, a_opnd, b_opnd;
  dlmsh_pkg::word_t res, res_plus_hi, cache_sum;

  // Derive the per-lane odd keys
  always_comb begin
    key_b1 = k1_q | 32'h1;
    key_b2 = k2_q | 32'h1;
    key_a1 = key_b1 + dlmsh_pkg::KeyA1Offset;
    key_a2 = key_b2 + dlmsh_pkg::KeyA2Offset;
  end

  // Select multiplier operands
  always_comb begin
    v_sel  = (ctl.op.lane == dlmsh_pkg::LANE_A) ? v_a : v_b;
    b_opnd = ctl.op.use_hi ? {16'h0, v_sel[31:16]} : v_sel;
    unique case (ctl.op.asel)
      dlmsh_pkg::ASEL_KEY_A1: a_opnd = key_a1;
      dlmsh_pkg::ASEL_KEY_A2: a_opnd = key_a2;
      dlmsh_pkg::ASEL_KEY_B1: a_opnd = key_b1;
      dlmsh_pkg::ASEL_KEY_B2: a_opnd = key_b2;
      default:                a_opnd = ctl.op.coef;
    endcase
  end

  // Fold the registered product into the running step value
  always_comb begin
    case (pend.mode)
      dlmsh_pkg::MODE_ADD: res = acc + prod;
      dlmsh_pkg::MODE_SUB: res = acc - prod;
      default:             res = prod;
    endcase
    res_plus_hi = res + hi_q;
    if (pend.lane == dlmsh_pkg::LANE_A) begin
      cache_sum = a_cache + t_a + res;
    end else begin
      cache_sum = b_cache + t_b + res;
    end
  end

  // Multiply stage: low 32 bits of the product
  always_ff @(posedge clk) begin
    prod <= a_opnd * b_opnd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else begin
      pend.valid <= ctl.op.issue;
      pend.lane  <= ctl.op.lane;
      pend.mode  <= ctl.op.mode;
      pend.post  <= ctl.op.post;
    end
  end

  // Latch the chunk's high word and both keys
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      hi_q <= word_high;
      k1_q <= key_first;
      k2_q <= key_second;
    end
  end

  // Working values of each chain
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      v_a <= word_low + a_hash;
      v_b <= word_low + b_hash;
    end else if (pend.valid) begin
      if (pend.mode == dlmsh_pkg::MODE_LOAD) begin
        acc <= prod;
      end else begin
        case (pend.post)
          dlmsh_pkg::POST_V: begin
            if (pend.lane == dlmsh_pkg::LANE_A) v_a <= res;
            else v_b <= res;
          end
          dlmsh_pkg::POST_T: begin
            if (pend.lane == dlmsh_pkg::LANE_A) begin
              v_a <= res_plus_hi;
              t_a <= res;
            end else begin
              v_b <= res_plus_hi;
              t_b <= res;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // Running hash and cache of each lane; clear after a digest
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      a_hash  <= '0;
      a_cache <= '0;
      b_hash  <= '0;
      b_cache <= '0;
    end else if (pend.valid && pend.mode != dlmsh_pkg::MODE_LOAD &&
                 pend.post == dlmsh_pkg::POST_HASH) begin
      if (pend.lane == dlmsh_pkg::LANE_A) begin
        a_hash  <= res;
        a_cache <= cache_sum;
      end else begin
        b_hash  <= res;
        b_cache <= cache_sum;
      end
    end
  end

  assign digest_low  = a_hash ^ b_hash;
  assign digest_high = a_cache ^ b_cache;

endmodule

`default_nettype wire

[hdl/dual_lane_multiply_shift_hash_unit.sv]
// Each accepted chunk passes through the handshake in the idle state, the 33-step issue program of the single
// shared 32x32 multiplier (30 products for the two lanes, interleaved, plus three bubbles
// where lane B waits on its own previous result), a drain state that folds the last product, and
// a finish state. On a chunk marked last the finish state loads the digest into the output
// register and clears both lanes; if an earlier digest is still waiting there, it holds until
// that digest is taken. The next chunk is accepted right after the finish state.
`default_nettype none
`include "assert_macros.svh"

module dual_lane_multiply_shift_hash_unit (
  input  logic         clk,
  input  logic         rst,
  dlmsh_in_if.sink     chunk,
  dlmsh_out_if.source  digest
);

  dlmsh_pkg::state_t    state, state_next;
  dlmsh_pkg::step_idx_t step;
  dlmsh_pkg::lane_ctl_t ctl;
  dlmsh_pkg::word_t     lane_low, lane_high;
  dlmsh_pkg::word_t     out_low, out_high;
  logic                 last_q;
  logic                 out_valid;
  logic                 accept;
  logic                 finish_fire;

  dlmsh_lanes u_lanes (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .word_low    (chunk.word_low),
    .word_high   (chunk.word_high),
    .key_first   (chunk.key_first),
    .key_second  (chunk.key_second),
    .digest_low  (lane_low),
    .digest_high (lane_high)
  );

  assign accept      = chunk.valid && (state == dlmsh_pkg::ST_IDLE);
  assign finish_fire = (state == dlmsh_pkg::ST_FINISH) && last_q &&
                       (!out_valid || digest.ready);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      dlmsh_pkg::ST_IDLE:   if (chunk.valid) state_next = dlmsh_pkg::ST_RUN;
      dlmsh_pkg::ST_RUN:    if (step == dlmsh_pkg::LastStep) state_next = dlmsh_pkg::ST_DRAIN;
      dlmsh_pkg::ST_DRAIN:  state_next = dlmsh_pkg::ST_FINISH;
      dlmsh_pkg::ST_FINISH: begin
        if (!last_q || finish_fire) state_next = dlmsh_pkg::ST_IDLE;
      end
      default:              state_next = dlmsh_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    ctl.start = accept;
    ctl.clear = finish_fire;
    ctl.op    = (state == dlmsh_pkg::ST_RUN) ? dlmsh_pkg::prog(step) : dlmsh_pkg::OpIdle;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dlmsh_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Advance the program step while running
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else if (state == dlmsh_pkg::ST_RUN && step != dlmsh_pkg::LastStep) begin
      step <= step + dlmsh_pkg::step_idx_t'(1);
    end else begin
      step <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_q <= 1'b0;
    end else if (accept) begin
      last_q <= chunk.last_chunk;
    end
  end

  // Hold the digest word until the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish_fire) begin
      out_valid <= 1'b1;
    end else if (digest.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish_fire) begin
      out_low  <= lane_low;
      out_high <= lane_high;
    end
  end

  assign chunk.ready        = (state == dlmsh_pkg::ST_IDLE);
  assign digest.valid       = out_valid;
  assign digest.digest_low  = out_low;
  assign digest.digest_high = out_high;

  `CHECK_NEXT(a_accept_runs, clk, rst, chunk.valid && chunk.ready, (state == dlmsh_pkg::ST_RUN) && (step == '0), "accepted word did not start the program")
  `CHECK_IMPLY(a_result_from_finish, clk, rst, $rose(out_valid), $past(state == dlmsh_pkg::ST_FINISH) && $past(last_q), "digest raised outside finish of a last chunk")
  `CHECK_IMPLY(a_step_only_running, clk, rst, state != dlmsh_pkg::ST_RUN, step == '0, "program step moved outside run")

endmodule

`default_nettype wire

[bench/dual_lane_multiply_shift_hash_unit_tb.sv]
`timescale 1ns / 1ps
// Self-checking bench: directed and random chunk streams against a built-in predictor of the two hash lanes.
module dual_lane_multiply_shift_hash_unit_tb;

  localparam int unsigned RandomChunks = 500;
  localparam int unsigned MaxGap       = 6;
  localparam int unsigned HoldCycles   = 400;
  localparam int unsigned HoldAfter    = 150;
  localparam int unsigned IdleLimit    = 3000;
  localparam int unsigned DrainCycles  = 48;
  localparam int unsigned AgeLimit     = 48;
  localparam int unsigned ReportLimit  = 10;

  typedef struct packed {
    dlmsh_pkg::word_t lo;
    dlmsh_pkg::word_t hi;
    dlmsh_pkg::word_t key1;
    dlmsh_pkg::word_t key2;
    logic             last;
  } chunk_t;

  typedef struct packed {
    dlmsh_pkg::word_t low;
    dlmsh_pkg::word_t high;
  } digest_t;

  logic clk;
  logic rst;

  dlmsh_in_if  chunk();
  dlmsh_out_if digest();

  dual_lane_multiply_shift_hash_unit dut (
    .clk    (clk),
    .rst    (rst),
    .chunk  (chunk),
    .digest (digest)
  );

  chunk_t  pending_chunks[$];
  digest_t digests_due[$];

  // Predicted lane state
  dlmsh_pkg::word_t a_hash, a_cache, b_hash, b_cache;

  int unsigned chunks_sent, digests_seen, mismatches, messages;
  int unsigned send_wait, send_age, recv_wait, hold_left;
  int unsigned idle_run, stall_run, longest_stall;
  logic        send_calm, recv_calm, hold_done;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Advance both lanes by one chunk; queue a digest on the last chunk and clear
  task automatic hash_chunk(input chunk_t c);
    dlmsh_pkg::word_t ka, kb, x, p, q, t, u, v, w, acc;
    dlmsh_pkg::word_t bx, ba, bb, bc, bt, bd, be, bf, bg;
    // lane A: keys forced odd plus fixed offsets
    ka = (c.key1 | 32'd1) + 32'h69FB_0000;
    kb = (c.key2 | 32'd1) + 32'h13DB_0000;
    x = c.lo + a_hash;
    p = x * ka - 32'h10FA_9605 * (x >> 16);
    q = 32'h79F8_A395 * p + 32'h689B_6B9F * (p >> 16);
    t = 32'hEA97_0001 * q - 32'h3C10_1569 * (q >> 16);
    u = t + c.hi;
    acc = a_cache + t;
    v = u * kb - 32'h3CE8_EC25 * (u >> 16);
    w = 32'h59C3_AF2D * v - 32'h2232_E0F1 * (v >> 16);
    a_hash = 32'h1EC9_0001 * w + 32'h35BD_1EC9 * (w >> 16);
    a_cache = acc + a_hash;
    // lane B: keys only forced odd
    ka = c.key1 | 32'd1;
    kb = c.key2 | 32'd1;
    bx = (c.lo + b_hash) * ka;
    ba = 32'hB111_0000 * bx - 32'h3067_4EEF * (bx >> 16);
    bb = 32'h5B9F_0000 * ba - 32'h78F7_A461 * (ba >> 16);
    bc = 32'h12CE_B96D * (bb >> 16) - 32'h4693_0000 * bb;
    bt = 32'h1D83_0000 * bc + 32'h257E_1D83 * (bc >> 16);
    bd = kb * (bt + c.hi);
    be = 32'h16F5_0000 * bd - 32'h5D8B_E90B * (bd >> 16);
    bf = 32'h96FF_0000 * be - 32'h2C7C_6901 * (be >> 16);
    bg = 32'h2B89_0000 * bf + 32'h7C93_2B89 * (bf >> 16);
    b_hash = 32'h9F69_0000 * bg - 32'h405B_6097 * (bg >> 16);
    b_cache = b_hash + b_cache + bt;
    if (c.last) begin
      digests_due.push_back('{low: a_hash ^ b_hash, high: a_cache ^ b_cache});
      a_hash = '0;
      a_cache = '0;
      b_hash = '0;
      b_cache = '0;
    end
  endtask

  // Favor all-zero, all-one and one-hot words now and then
  function automatic dlmsh_pkg::word_t pick_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return dlmsh_pkg::word_t'(1) << $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  task automatic push_chunk(input dlmsh_pkg::word_t lo, input dlmsh_pkg::word_t hi,
                            input dlmsh_pkg::word_t key1, input dlmsh_pkg::word_t key2,
                            input logic last);
    pending_chunks.push_back('{lo: lo, hi: hi, key1: key1, key2: key2, last: last});
    if (last) messages++;
  endtask

  // One message of len chunks; keys fixed unless shifting_keys
  task automatic add_message(input int unsigned len, input bit shifting_keys);
    dlmsh_pkg::word_t k1, k2;
    k1 = pick_word();
    k2 = pick_word();
    for (int unsigned i = 0; i < len; i++) begin
      if (shifting_keys) begin
        k1 = pick_word();
        k2 = pick_word();
      end
      push_chunk(pick_word(), pick_word(), k1, k2, i == len - 1);
    end
  endtask

  task automatic check_word(input string field, input dlmsh_pkg::word_t want,
                            input dlmsh_pkg::word_t got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= ReportLimit)
        $display("%t %s mismatch: expected %h, got %h", $realtime, field, want, got);
    end
  endtask

  // Sender: offer queued words, with a drawn gap after each one once the block is ready
  always @(posedge clk) begin : driver
    chunk_t nxt;
    chunk_t took;
    int unsigned w;
    if (rst) begin
      chunk.valid <= 1'b0;
      send_wait <= 0;
      send_age <= 0;
    end else if (!chunk.valid || chunk.ready) begin
      w = send_wait;
      if (chunk.valid) begin
        took.lo = chunk.word_low;
        took.hi = chunk.word_high;
        took.key1 = chunk.key_first;
        took.key2 = chunk.key_second;
        took.last = chunk.last_chunk;
        hash_chunk(took);
        chunks_sent <= chunks_sent + 1;
        w = send_calm ? 0 : $urandom_range(0, MaxGap);
        if ($urandom_range(0, 29) == 0) send_calm <= !send_calm;
        send_age <= 0;
      end else begin
        if (w != 0 && (chunk.ready || send_age >= AgeLimit)) w = w - 1;
        send_age <= send_age + 1;
      end
      if (w == 0 && pending_chunks.size() != 0) begin
        nxt = pending_chunks.pop_front();
        chunk.valid <= 1'b1;
        chunk.word_low <= nxt.lo;
        chunk.word_high <= nxt.hi;
        chunk.key_first <= nxt.key1;
        chunk.key_second <= nxt.key2;
        chunk.last_chunk <= nxt.last;
      end else begin
        chunk.valid <= 1'b0;
      end
      send_wait <= w;
    end
  end

  // Long receiver hold-off once, so the output register fills and the input stalls
  always @(posedge clk) begin : holdoff
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && chunks_sent >= HoldAfter) begin
      hold_left <= HoldCycles;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Receiver: check each digest word against the oldest prediction
  always @(posedge clk) begin : receiver
    digest_t want;
    int unsigned w;
    if (rst) begin
      digest.ready <= 1'b0;
      recv_wait <= 0;
    end else begin
      w = recv_wait;
      if (digest.valid && digest.ready) begin
        digests_seen <= digests_seen + 1;
        if (digests_due.size() == 0) begin
          mismatches++;
          if (mismatches <= ReportLimit)
            $display("%t digest %h_%h arrived with none outstanding", $realtime,
                     digest.digest_high, digest.digest_low);
        end else begin
          want = digests_due.pop_front();
          check_word("digest_low", want.low, digest.digest_low);
          check_word("digest_high", want.high, digest.digest_high);
        end
        w = recv_calm ? 0 : $urandom_range(0, MaxGap);
        if ($urandom_range(0, 29) == 0) recv_calm <= !recv_calm;
      end else if (digest.valid && w != 0) begin
        w = w - 1;
      end
      recv_wait <= w;
      digest.ready <= (w == 0) && (hold_left == 0);
    end
  end

  // Track progress and the longest input stall
  always @(posedge clk) begin : watchdog
    if (rst) begin
      idle_run <= 0;
      stall_run <= 0;
      longest_stall <= 0;
    end else begin
      if ((chunk.valid && chunk.ready) || (digest.valid && digest.ready))
        idle_run <= 0;
      else
        idle_run <= idle_run + 1;
      if (chunk.valid && !chunk.ready)
        stall_run <= stall_run + 1;
      else
        stall_run <= 0;
      if (stall_run > longest_stall) longest_stall <= stall_run;
    end
  end

  initial begin : main
    int unsigned directed_n;
    rst = 1'b1;
    chunk.valid = 1'b0;
    chunk.word_low = '0;
    chunk.word_high = '0;
    chunk.key_first = '0;
    chunk.key_second = '0;
    chunk.last_chunk = 1'b0;
    digest.ready = 1'b0;
    a_hash = '0;
    a_cache = '0;
    b_hash = '0;
    b_cache = '0;
    send_calm = 1'b0;
    recv_calm = 1'b0;

    // all zero, all one and value-one single-chunk messages
    push_chunk('0, '0, '0, '0, 1'b1);
    push_chunk('1, '1, '1, '1, 1'b1);
    push_chunk(32'd1, 32'd1, 32'd1, 32'd1, 1'b1);
    // even keys get forced odd
    push_chunk(32'h1234_5678, 32'h9ABC_DEF0, 32'hFFFF_FFFE, 32'h0000_0000, 1'b1);
    // lane A key offsets wrap past 32 bits
    push_chunk('1, '0, 32'h9605_0000, 32'hEC25_0000, 1'b0);
    push_chunk('0, '1, 32'h9605_0000, 32'hEC25_0000, 1'b1);
    // alternating extremes within one message
    push_chunk('0, '1, 32'h0000_FFFF, 32'hFFFF_0000, 1'b0);
    push_chunk('1, '0, 32'h0000_FFFF, 32'hFFFF_0000, 1'b0);
    push_chunk(32'h8000_0000, 32'h0000_0001, 32'h0000_FFFF, 32'hFFFF_0000, 1'b0);
    push_chunk(32'h0000_0001, 32'h8000_0000, 32'h0000_FFFF, 32'hFFFF_0000, 1'b1);
    // keys changing mid-message, then a longer message
    add_message(3, 1'b1);
    add_message(6, 1'b0);
    directed_n = pending_chunks.size();

    // mostly short well-formed messages, some long, a few with shifting keys
    while (pending_chunks.size() < directed_n + RandomChunks)
      add_message(($urandom_range(0, 7) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4),
                  $urandom_range(0, 9) == 0);

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while ((pending_chunks.size() != 0 || chunk.valid || digests_due.size() != 0)
           && idle_run < IdleLimit)
      @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (idle_run >= IdleLimit) begin
      $display("no handshake for %0d cycles, %0d digests outstanding", idle_run,
               digests_due.size());
      $display("FAIL");
    end else begin
      $display("covered %0d chunks in %0d messages, %0d digests checked, %0d mismatches",
               chunks_sent, messages, digests_seen, mismatches);
      $display("longest input stall under output back-pressure: %0d cycles", longest_stall);
      if (mismatches == 0 && digests_due.size() == 0)
        $display("PASS");
      else
        $display("FAIL");
    end
    $finish;
  end

endmodule

[dual_lane_multiply_shift_hash_unit.f]
+incdir+hdl
hdl/dlmsh_pkg.sv
hdl/dlmsh_in_if.sv
hdl/dlmsh_out_if.sv
hdl/dlmsh_lanes.sv
hdl/dual_lane_multiply_shift_hash_unit.sv
bench/dual_lane_multiply_shift_hash_unit_tb.sv
